@@ hdl/ccp_pkg.sv @@
// ccp_pkg: widths, payload types and codes shared by the cubic curve point core
// no dependencies; compile first

package ccp_pkg;

   localparam int CRD_W = 16;               // input coordinate
   localparam int STEP_W = 8;               // step index
   localparam int SEG_W = 8;                // curve parameter s, at most the segment count
   localparam int TAN_W = 19;               // tangent after bezier conversion
   localparam int SQ_W = 16;                // s^2
   localparam int CUB_W = 24;               // s^3, n*s^2, n^2*s
   localparam int WGT_W = 27;               // signed basis weight
   localparam int PP_W = CRD_W + WGT_W;     // point times weight
   localparam int TP_W = TAN_W + WGT_W;     // tangent times weight
   localparam int SUM_W = 48;               // weighted sum
   localparam int MAG_W = SUM_W - 1;        // magnitude of the weighted sum
   localparam int QUO_W = 17;               // quotient magnitude
   localparam int PNT_W = 18;               // result coordinate

   typedef logic signed [CRD_W-1:0] crd_type;
   typedef logic signed [TAN_W-1:0] tan_type;
   typedef logic signed [WGT_W-1:0] wgt_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [PNT_W-1:0] pnt_type;

   typedef enum logic {
      FORM_HERMITE = 1'b0,
      FORM_BEZIER  = 1'b1
   } form_type;

   // classified request handed from the front end to the back end
   typedef struct packed {
      logic [SEG_W-1:0] s;
      crd_type p1x;
      crd_type p1y;
      crd_type p2x;
      crd_type p2y;
      tan_type t1x;
      tan_type t1y;
      tan_type t2x;
      tan_type t2y;
   } job_type;

   typedef struct packed {
      logic neg;
      logic [QUO_W-1:0] quo;
   } quo_type;

endpackage

@@ hdl/ccp_req_if.sv @@
// ccp_req_if: request channel of the cubic curve point core
// depends on ccp_pkg

interface ccp_req_if;
   logic valid;
   logic ready;
   ccp_pkg::crd_type start_x;
   ccp_pkg::crd_type start_y;
   ccp_pkg::crd_type end_x;
   ccp_pkg::crd_type end_y;
   ccp_pkg::crd_type first_aux_x;
   ccp_pkg::crd_type first_aux_y;
   ccp_pkg::crd_type second_aux_x;
   ccp_pkg::crd_type second_aux_y;
   logic [ccp_pkg::STEP_W-1:0] step_index;

   modport source (
      output valid, start_x, start_y, end_x, end_y,
      output first_aux_x, first_aux_y, second_aux_x, second_aux_y, step_index,
      input ready
   );
   modport sink (
      input valid, start_x, start_y, end_x, end_y,
      input first_aux_x, first_aux_y, second_aux_x, second_aux_y, step_index,
      output ready
   );
endinterface

@@ hdl/ccp_rsp_if.sv @@
// ccp_rsp_if: response channel of the cubic curve point core
// depends on ccp_pkg

interface ccp_rsp_if;
   logic valid;
   logic ready;
   ccp_pkg::pnt_type point_x;
   ccp_pkg::pnt_type point_y;

   modport source (output valid, point_x, point_y, input ready);
   modport sink (input valid, point_x, point_y, output ready);
endinterface

@@ hdl/ccp_front.sv @@
// ccp_front: accepts requests, clamps the step and forms the tangents
// depends on ccp_pkg and ccp_req_if

module ccp_front #(
   parameter int SEGMENTS = 150
) (
   input  logic clock,
   input  logic reset,
   input  ccp_pkg::form_type curve_form,
   ccp_req_if.sink req,
   output ccp_pkg::job_type job,
   output logic job_valid,
   input  logic job_ready
);

   localparam logic [ccp_pkg::SEG_W-1:0] SEG_N = ccp_pkg::SEG_W'(SEGMENTS);
   localparam logic [ccp_pkg::SEG_W-1:0] SEG_LAST = ccp_pkg::SEG_W'(SEGMENTS - 1);

   // 3 * (a - b), exact in the tangent width
   function automatic ccp_pkg::tan_type bez_tan(ccp_pkg::crd_type a, ccp_pkg::crd_type b);
      ccp_pkg::tan_type d;
      d = ccp_pkg::TAN_W'(a) - ccp_pkg::TAN_W'(b);
      return d + (d <<< 1);
   endfunction

   logic job_valid_ff, job_valid_in;
   ccp_pkg::job_type job_ff, job_in;
   logic accept;

   assign req.ready = !job_valid_ff || job_ready;
   assign accept = req.valid && req.ready;

   always_comb begin
      if (req.step_index >= SEG_LAST) begin
         job_in.s = SEG_N;
      end else begin
         job_in.s = req.step_index + ccp_pkg::SEG_W'(1);
      end
      job_in.p1x = req.start_x;
      job_in.p1y = req.start_y;
      job_in.p2x = req.end_x;
      job_in.p2y = req.end_y;
      if (curve_form == ccp_pkg::FORM_BEZIER) begin
         job_in.t1x = bez_tan(req.first_aux_x, req.start_x);
         job_in.t1y = bez_tan(req.first_aux_y, req.start_y);
         job_in.t2x = bez_tan(req.end_x, req.second_aux_x);
         job_in.t2y = bez_tan(req.end_y, req.second_aux_y);
      end else begin
         job_in.t1x = ccp_pkg::TAN_W'(req.first_aux_x);
         job_in.t1y = ccp_pkg::TAN_W'(req.first_aux_y);
         job_in.t2x = ccp_pkg::TAN_W'(req.second_aux_x);
         job_in.t2y = ccp_pkg::TAN_W'(req.second_aux_y);
      end
   end

   always_comb begin
      if (accept) begin
         job_valid_in = 1'b1;
      end else if (job_ready) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job = job_ff;
   assign job_valid = job_valid_ff;

endmodule

@@ hdl/ccp_queue.sv @@
// ccp_queue: two-entry queue between the front and back ends
// depends on ccp_pkg

module ccp_queue (
   input  logic clock,
   input  logic reset,
   input  ccp_pkg::job_type in_job,
   input  logic in_valid,
   output logic in_ready,
   output ccp_pkg::job_type out_job,
   output logic out_valid,
   input  logic out_ready
);

   localparam int DEPTH = 2;

   ccp_pkg::job_type mem_ff [DEPTH];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready = count_ff != 2'(DEPTH);
   assign out_valid = count_ff != 2'd0;
   assign out_job = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

@@ hdl/ccp_div.sv @@
// ccp_div: pipelined division of two signed sums by segments cubed
// depends on ccp_pkg; reciprocal estimate plus a compare correction, truncation toward zero

module ccp_div #(
   parameter int SEGMENTS = 150
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  ccp_pkg::sum_type sum_x,
   input  ccp_pkg::sum_type sum_y,
   output logic out_valid,
   output ccp_pkg::quo_type res_x,
   output ccp_pkg::quo_type res_y
);

   localparam int QW = ccp_pkg::QUO_W;
   localparam int MW = ccp_pkg::MAG_W;
   localparam int FW = QW + 1;              // magnitude slice, reciprocal and estimate
   localparam int PW = 2 * FW;              // estimate product
   localparam longint DIV_VAL = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
   localparam int DW = $clog2(DIV_VAL + 1);
   localparam int BW = FW + DW;             // estimate times divisor
   // divisor lies in (2^SH, 2^(SH+1)], so the reciprocal fills FW bits
   localparam int SH = $clog2(DIV_VAL) - 1;
   localparam logic [FW-1:0] RECIP = FW'((longint'(1) <<< (SH + FW)) / DIV_VAL);
   localparam logic [DW-1:0] DIV_LOW = DW'(DIV_VAL);
   localparam logic [MW-1:0] DIVISOR = MW'(DIV_VAL);
   localparam logic [MW-1:0] DIVISOR2 = MW'(2 * DIV_VAL);

   logic [4:0] vld_ff, vld_in;
   ccp_pkg::sum_type sum_lane [2];
   ccp_pkg::quo_type res_lane [2];

   assign sum_lane[0] = sum_x;
   assign sum_lane[1] = sum_y;
   assign res_x = res_lane[0];
   assign res_y = res_lane[1];
   assign out_valid = vld_ff[4];

   assign vld_in = en ? {vld_ff[3:0], in_valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   for (genvar lane = 0; lane < 2; lane++) begin : g_lane
      logic [MW-1:0] mag;
      logic [FW-1:0] est;
      logic [FW-1:0] quo_sum;
      logic [MW-1:0] mag_a_ff, mag_b_ff, mag_c_ff;
      logic [PW-1:0] prod_b_ff;
      logic [FW-1:0] est_c_ff, est_d_ff;
      logic [BW-1:0] back_c_ff;
      logic [MW-1:0] rem_d_ff;
      logic [QW-1:0] quo_e_ff;
      logic neg_a_ff, neg_b_ff, neg_c_ff, neg_d_ff, neg_e_ff;

      assign mag = sum_lane[lane][ccp_pkg::SUM_W-1] ? MW'(-sum_lane[lane])
                                                    : MW'(sum_lane[lane]);

      // estimate from the top bits of the magnitude, low by at most two
      assign est = prod_b_ff[PW-1:FW];
      assign quo_sum = est_d_ff + FW'(rem_d_ff >= DIVISOR) + FW'(rem_d_ff >= DIVISOR2);

      always_ff @(posedge clock) begin
         if (en) begin
            mag_a_ff <= mag;
            neg_a_ff <= sum_lane[lane][ccp_pkg::SUM_W-1];

            prod_b_ff <= PW'(mag_a_ff[SH +: FW]) * PW'(RECIP);
            mag_b_ff <= mag_a_ff;
            neg_b_ff <= neg_a_ff;

            est_c_ff <= est;
            back_c_ff <= BW'(est) * BW'(DIV_LOW);
            mag_c_ff <= mag_b_ff;
            neg_c_ff <= neg_b_ff;

            est_d_ff <= est_c_ff;
            rem_d_ff <= mag_c_ff - MW'(back_c_ff);
            neg_d_ff <= neg_c_ff;

            quo_e_ff <= QW'(quo_sum);
            neg_e_ff <= neg_d_ff;
         end
      end

      assign res_lane[lane].neg = neg_e_ff;
      assign res_lane[lane].quo = quo_e_ff;
   end

endmodule

@@ hdl/ccp_back.sv @@
// ccp_back: basis weights, weighted sums, division and the response register
// depends on ccp_pkg, ccp_div and ccp_rsp_if

module ccp_back #(
   parameter int SEGMENTS = 150
) (
   input  logic clock,
   input  logic reset,
   input  ccp_pkg::job_type job,
   input  logic job_valid,
   output logic job_ready,
   ccp_rsp_if.source rsp
);

   localparam ccp_pkg::wgt_type N_CUBE = ccp_pkg::WGT_W'(SEGMENTS * SEGMENTS * SEGMENTS);

   logic en;
   logic [5:0] vld_ff, vld_in;
   logic out_valid_ff, out_valid_in;
   logic div_valid;
   ccp_pkg::quo_type res_x, res_y;

   // stage 1: s^2
   ccp_pkg::job_type job1_ff;
   logic [ccp_pkg::SQ_W-1:0] sq1_ff;
   // stage 2: s^3, n*s^2, n^2*s
   ccp_pkg::job_type job2_ff;
   logic [ccp_pkg::CUB_W-1:0] cube2_ff, nsq2_ff, n2s2_ff;
   // stage 3: weights
   ccp_pkg::job_type job3_ff;
   ccp_pkg::wgt_type m1_ff, m2_ff, m3_ff, m4_ff;
   ccp_pkg::wgt_type cw, nw, n2w;
   // stage 4: products
   logic signed [ccp_pkg::PP_W-1:0] px1_ff, px2_ff, py1_ff, py2_ff;
   logic signed [ccp_pkg::TP_W-1:0] tx1_ff, tx2_ff, ty1_ff, ty2_ff;
   // stage 5 and 6: sums
   ccp_pkg::sum_type ax_ff, bx_ff, ay_ff, by_ff;
   ccp_pkg::sum_type sumx_ff, sumy_ff;
   ccp_pkg::pnt_type point_x_ff, point_y_ff;

   assign en = !out_valid_ff || rsp.ready;
   assign job_ready = en;

   assign vld_in = en ? {vld_ff[4:0], job_valid} : vld_ff;
   assign out_valid_in = en ? div_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign cw = $signed(ccp_pkg::WGT_W'(cube2_ff));
   assign nw = $signed(ccp_pkg::WGT_W'(nsq2_ff));
   assign n2w = $signed(ccp_pkg::WGT_W'(n2s2_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         job1_ff <= job;
         sq1_ff <= ccp_pkg::SQ_W'(job.s) * ccp_pkg::SQ_W'(job.s);

         job2_ff <= job1_ff;
         cube2_ff <= ccp_pkg::CUB_W'(sq1_ff) * ccp_pkg::CUB_W'(job1_ff.s);
         nsq2_ff <= ccp_pkg::CUB_W'(sq1_ff) * ccp_pkg::CUB_W'(SEGMENTS);
         n2s2_ff <= ccp_pkg::CUB_W'(SEGMENTS * SEGMENTS) * ccp_pkg::CUB_W'(job1_ff.s);

         job3_ff <= job2_ff;
         m1_ff <= (cw <<< 1) - nw - (nw <<< 1) + N_CUBE;
         m2_ff <= nw + (nw <<< 1) - (cw <<< 1);
         m3_ff <= cw - (nw <<< 1) + n2w;
         m4_ff <= cw - nw;

         px1_ff <= ccp_pkg::PP_W'(job3_ff.p1x) * ccp_pkg::PP_W'(m1_ff);
         px2_ff <= ccp_pkg::PP_W'(job3_ff.p2x) * ccp_pkg::PP_W'(m2_ff);
         py1_ff <= ccp_pkg::PP_W'(job3_ff.p1y) * ccp_pkg::PP_W'(m1_ff);
         py2_ff <= ccp_pkg::PP_W'(job3_ff.p2y) * ccp_pkg::PP_W'(m2_ff);
         tx1_ff <= ccp_pkg::TP_W'(job3_ff.t1x) * ccp_pkg::TP_W'(m3_ff);
         tx2_ff <= ccp_pkg::TP_W'(job3_ff.t2x) * ccp_pkg::TP_W'(m4_ff);
         ty1_ff <= ccp_pkg::TP_W'(job3_ff.t1y) * ccp_pkg::TP_W'(m3_ff);
         ty2_ff <= ccp_pkg::TP_W'(job3_ff.t2y) * ccp_pkg::TP_W'(m4_ff);

         ax_ff <= ccp_pkg::SUM_W'(px1_ff) + ccp_pkg::SUM_W'(px2_ff);
         bx_ff <= ccp_pkg::SUM_W'(tx1_ff) + ccp_pkg::SUM_W'(tx2_ff);
         ay_ff <= ccp_pkg::SUM_W'(py1_ff) + ccp_pkg::SUM_W'(py2_ff);
         by_ff <= ccp_pkg::SUM_W'(ty1_ff) + ccp_pkg::SUM_W'(ty2_ff);

         sumx_ff <= ax_ff + bx_ff;
         sumy_ff <= ay_ff + by_ff;

         // restore the sign of the truncated quotient
         point_x_ff <= res_x.neg ? -ccp_pkg::PNT_W'(res_x.quo) : ccp_pkg::PNT_W'(res_x.quo);
         point_y_ff <= res_y.neg ? -ccp_pkg::PNT_W'(res_y.quo) : ccp_pkg::PNT_W'(res_y.quo);
      end
   end

   ccp_div #(
      .SEGMENTS(SEGMENTS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(vld_ff[5]),
      .sum_x(sumx_ff),
      .sum_y(sumy_ff),
      .out_valid(div_valid),
      .res_x(res_x),
      .res_y(res_y)
   );

   assign rsp.valid = out_valid_ff;
   assign rsp.point_x = point_x_ff;
   assign rsp.point_y = point_y_ff;

endmodule

@@ hdl/cubic_curve_point_core.sv @@
// cubic_curve_point_core: integer point on a hermite or bezier cubic per request
// depends on ccp_pkg, ccp_req_if, ccp_rsp_if, ccp_front, ccp_queue, ccp_back
//
// usage:
//   req carries two end points, two auxiliary points and a step index; rsp
//   returns one point per request, in request order, at t = s / SEGMENTS with
//   s = min(step_index, SEGMENTS-1) + 1. csr_we / csr_wdata set the curve form
//   (hermite tangents or bezier control points); write it only when idle.
// throughput: one request per cycle while rsp is not held off, set by the
//   fully pipelined back end (weight multipliers, products, sums and a
//   reciprocal divider).
// path: queue, six weight and sum stages, five divider stages, response
//   register; the front register loads at the accepting edge itself.
// stalls: when rsp is held off the back end freezes as a whole; the two-entry
//   queue and the front register then absorb requests before req.ready drops.
// reset: synchronous; empties the pipeline and the queue and selects hermite.

module cubic_curve_point_core #(
   parameter int SEGMENTS = 150
) (
   input  logic clock,
   input  logic reset,
   ccp_req_if.sink req,
   ccp_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [0:0] csr_wdata
);

   ccp_pkg::form_type curve_form_ff, curve_form_in;
   ccp_pkg::job_type front_job, queue_job;
   logic front_valid, q_ready, q_valid, back_ready;

   assign curve_form_in = csr_we ? ccp_pkg::form_type'(csr_wdata) : curve_form_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_form_ff <= ccp_pkg::FORM_HERMITE;
      end else begin
         curve_form_ff <= curve_form_in;
      end
   end

   ccp_front #(
      .SEGMENTS(SEGMENTS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .curve_form(curve_form_ff),
      .req(req),
      .job(front_job),
      .job_valid(front_valid),
      .job_ready(q_ready)
   );

   ccp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .in_job(front_job),
      .in_valid(front_valid),
      .in_ready(q_ready),
      .out_job(queue_job),
      .out_valid(q_valid),
      .out_ready(back_ready)
   );

   ccp_back #(
      .SEGMENTS(SEGMENTS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job(queue_job),
      .job_valid(q_valid),
      .job_ready(back_ready),
      .rsp(rsp)
   );

`ifndef SYNTHESIS
   // a stalled response must freeze the back end, so nothing leaves the queue
   a_stall_freezes_back: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !back_ready)
      else $error("back end advanced while response stalled");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid after reset");

   // a classified request waiting on a full queue is not dropped
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      (front_valid && !q_ready) |=> front_valid)
      else $error("front end dropped a request while queue was full");
`endif

endmodule
